>>> rtl/bgstf_pkg.sv
// package: constants and codes for the background scanline tile fetcher
`timescale 1ns / 1ps

package bgstf_pkg;

  localparam int unsigned LINE_PIXELS_DEF = 160;

  localparam logic [15:0] MAP_BASE  = 16'h9800;
  localparam logic [15:0] TILE_BASE = 16'h8000;
  localparam logic [15:0] TILE_HIGH = 16'h1000;

  // phase counter holds phase_count + 6, so lead-in ends at LEAD_IN
  localparam logic [4:0] LEAD_IN   = 5'd6;
  localparam logic [4:0] PIX_START = 5'd14;
  localparam logic [4:0] PC_WRAP   = 5'd22;
  localparam logic [4:0] PC_BACK   = 5'd8;

  typedef enum logic [1:0] {
    REG_MAP_SELECT  = 2'd0,
    REG_DATA_SELECT = 2'd1,
    REG_SCROLL_X    = 2'd2,
    REG_SCROLL_Y    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    PH_MAP_ADDR  = 3'd0,
    PH_ID_READ   = 3'd1,
    PH_DATA_ADDR = 3'd2,
    PH_TAKE_LOW  = 3'd3,
    PH_HIGH_ADDR = 3'd4,
    PH_TAKE_HIGH = 3'd5,
    PH_IDLE      = 3'd6,
    PH_NEXT_COL  = 3'd7
  } phase_t;

endpackage

>>> rtl/bg_scanline_tile_fetcher.sv
// top level: background scanline tile fetcher with registered result beat
// result beat: valid in the cycle after its tick beat is accepted
// throughput: one beat per cycle unless out_ready stalls; one state update per beat
// start beats and ticks while no line is active give no result beat
// reset (rst_n low, synchronous): line idle, result register empty, registers at defaults
`timescale 1ns / 1ps

module bg_scanline_tile_fetcher
  import bgstf_pkg::*;
#(
  parameter int unsigned LINE_PIXELS = LINE_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_line_number,
  input  logic [7:0]  in_bus_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_bus_address,
  output logic        out_address_valid,
  output logic        out_read_request,
  output logic        out_pixel_valid,
  output logic [7:0]  out_pixel_x,
  output logic [1:0]  out_pixel_color,
  output logic        out_line_done
);

  localparam logic [7:0] LAST_PIXEL = LINE_PIXELS[7:0];

  // configuration registers
  logic       map_select_r, data_select_r;
  logic [7:0] scroll_x_r, scroll_y_r;

  // line state
  logic        active_r, active_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [7:0]  pixels_done_r, pixels_done_nxt;
  logic [2:0]  fine_x_left_r, fine_x_left_nxt;
  logic [2:0]  fine_y_r, fine_y_nxt;
  logic [4:0]  tile_column_r, tile_column_nxt;
  logic [15:0] map_row_base_r, map_row_base_nxt;
  logic [7:0]  shift_lo_r, shift_lo_nxt, shift_hi_r, shift_hi_nxt;
  logic [7:0]  fetched_lo_r, fetched_lo_nxt, fetched_hi_r, fetched_hi_nxt;
  logic [15:0] held_address_r, held_address_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] bus_address_r;
  logic        address_valid_r, read_request_r, pixel_valid_r, line_done_r;
  logic [7:0]  pixel_x_r;
  logic [1:0]  pixel_color_r;

  logic        addr_valid_c, read_req_c, pix_valid_c, done_c;
  logic [7:0]  pix_x_c;
  logic [1:0]  pix_col_c;
  logic        take, emit;
  logic [7:0]  yoff;
  logic [7:0]  sh_lo, sh_hi;
  logic [4:0]  pc_inc;
  phase_t      phase;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign emit     = take && (in_opcode == OP_TICK) && active_r;
  assign yoff     = in_line_number + scroll_y_r;

  always_comb begin
    if (pc_r < LEAD_IN) begin
      phase = phase_t'(pc_r[2:0]);
    end else begin
      phase = phase_t'(pc_r[2:0] + 3'd2);
    end
  end

  always_comb begin
    active_nxt       = active_r;
    pc_nxt           = pc_r;
    pixels_done_nxt  = pixels_done_r;
    fine_x_left_nxt  = fine_x_left_r;
    fine_y_nxt       = fine_y_r;
    tile_column_nxt  = tile_column_r;
    map_row_base_nxt = map_row_base_r;
    shift_lo_nxt     = shift_lo_r;
    shift_hi_nxt     = shift_hi_r;
    fetched_lo_nxt   = fetched_lo_r;
    fetched_hi_nxt   = fetched_hi_r;
    held_address_nxt = held_address_r;
    addr_valid_c     = 1'b0;
    read_req_c       = 1'b0;
    pix_valid_c      = 1'b0;
    pix_x_c          = 8'd0;
    pix_col_c        = 2'd0;
    done_c           = 1'b0;
    sh_lo            = shift_lo_r;
    sh_hi            = shift_hi_r;
    pc_inc           = pc_r + 5'd1;

    if (take && in_opcode == OP_START) begin
      active_nxt       = 1'b1;
      pc_nxt           = 5'd0;
      pixels_done_nxt  = 8'd0;
      map_row_base_nxt = MAP_BASE | {5'd0, map_select_r, 10'd0} | {6'd0, yoff[7:3], 5'd0};
      tile_column_nxt  = scroll_x_r[7:3];
      fine_x_left_nxt  = scroll_x_r[2:0];
      fine_y_nxt       = yoff[2:0];
      shift_lo_nxt     = 8'd0;
      shift_hi_nxt     = 8'd0;
      fetched_lo_nxt   = 8'd0;
      fetched_hi_nxt   = 8'd0;
    end else if (emit) begin
      case (phase)
        PH_MAP_ADDR: begin
          sh_lo            = fetched_lo_r;
          sh_hi            = fetched_hi_r;
          held_address_nxt = map_row_base_r | {11'd0, tile_column_r};
          addr_valid_c     = 1'b1;
        end
        PH_ID_READ: begin
          read_req_c = 1'b1;
        end
        PH_DATA_ADDR: begin
          // signed tile ids below 0x80 sit in the upper bank
          held_address_nxt = TILE_BASE
                           | ((!data_select_r && !in_bus_data[7]) ? TILE_HIGH : 16'd0)
                           | {4'd0, in_bus_data, 4'd0}
                           | {12'd0, fine_y_r, 1'b0};
          addr_valid_c     = 1'b1;
          read_req_c       = 1'b1;
        end
        PH_TAKE_LOW: begin
          fetched_lo_nxt = in_bus_data;
        end
        PH_HIGH_ADDR: begin
          held_address_nxt = held_address_r + 16'd1;
          addr_valid_c     = 1'b1;
          read_req_c       = 1'b1;
        end
        PH_TAKE_HIGH: begin
          fetched_hi_nxt = in_bus_data;
        end
        PH_IDLE: begin
        end
        PH_NEXT_COL: begin
          tile_column_nxt = tile_column_r + 5'd1;
        end
        default: begin
        end
      endcase

      if (pc_r >= PIX_START) begin
        if (fine_x_left_r == 3'd0) begin
          pix_valid_c     = 1'b1;
          pix_x_c         = pixels_done_r;
          pix_col_c       = {sh_hi[7], sh_lo[7]};
          pixels_done_nxt = pixels_done_r + 8'd1;
        end else begin
          fine_x_left_nxt = fine_x_left_r - 3'd1;
        end
      end

      // long lines fold the counter back one tile
      pc_nxt       = (pc_inc >= PC_WRAP) ? pc_inc - PC_BACK : pc_inc;
      shift_lo_nxt = {sh_lo[6:0], 1'b0};
      shift_hi_nxt = {sh_hi[6:0], 1'b0};

      if (pixels_done_nxt == LAST_PIXEL) begin
        done_c     = 1'b1;
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_select_r  <= 1'b0;
      data_select_r <= 1'b1;
      scroll_x_r    <= 8'd0;
      scroll_y_r    <= 8'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAP_SELECT:  map_select_r  <= cfg_data[0];
        REG_DATA_SELECT: data_select_r <= cfg_data[0];
        REG_SCROLL_X:    scroll_x_r    <= cfg_data;
        REG_SCROLL_Y:    scroll_y_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      pc_r           <= 5'd0;
      pixels_done_r  <= 8'd0;
      fine_x_left_r  <= 3'd0;
      fine_y_r       <= 3'd0;
      tile_column_r  <= 5'd0;
      map_row_base_r <= MAP_BASE;
      shift_lo_r     <= 8'd0;
      shift_hi_r     <= 8'd0;
      fetched_lo_r   <= 8'd0;
      fetched_hi_r   <= 8'd0;
      held_address_r <= 16'd0;
      out_valid_r    <= 1'b0;
    end else begin
      active_r       <= active_nxt;
      pc_r           <= pc_nxt;
      pixels_done_r  <= pixels_done_nxt;
      fine_x_left_r  <= fine_x_left_nxt;
      fine_y_r       <= fine_y_nxt;
      tile_column_r  <= tile_column_nxt;
      map_row_base_r <= map_row_base_nxt;
      shift_lo_r     <= shift_lo_nxt;
      shift_hi_r     <= shift_hi_nxt;
      fetched_lo_r   <= fetched_lo_nxt;
      fetched_hi_r   <= fetched_hi_nxt;
      held_address_r <= held_address_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_address_r   <= held_address_nxt;
      address_valid_r <= addr_valid_c;
      read_request_r  <= read_req_c;
      pixel_valid_r   <= pix_valid_c;
      pixel_x_r       <= pix_x_c;
      pixel_color_r   <= pix_col_c;
      line_done_r     <= done_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bus_address   = bus_address_r;
  assign out_address_valid = address_valid_r;
  assign out_read_request  = read_request_r;
  assign out_pixel_valid   = pixel_valid_r;
  assign out_pixel_x       = pixel_x_r;
  assign out_pixel_color   = pixel_color_r;
  assign out_line_done     = line_done_r;

endmodule

>>> bench/fetch_check_pkg.sv
// scoreboard for the background tile fetcher: line predictor and result checker
`timescale 1ns / 1ps

package fetch_check_pkg;

  import bgstf_pkg::*;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        address_valid;
    logic        read_request;
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [1:0]  pixel_color;
    logic        line_done;
  } fetch_beat_t;

  class fetch_scoreboard;
    int unsigned fails;
    int unsigned line_len;

    logic       map_sel;
    logic       data_sel;
    logic [7:0] scx;
    logic [7:0] scy;

    bit          active;
    int          phase_count;
    logic [7:0]  pixels_done;
    logic [2:0]  fine_x_left;
    logic [2:0]  fine_y;
    logic [4:0]  tile_col;
    logic [15:0] row_base;
    logic [15:0] held_addr;
    logic [7:0]  shift_lo, shift_hi;
    logic [7:0]  fetch_lo, fetch_hi;

    fetch_beat_t expected_beats[$];

    function new(int unsigned len);
      line_len = len;
      fails = 0;
      map_sel = 1'b0;
      data_sel = 1'b1;
      scx = '0;
      scy = '0;
      active = 1'b0;
      phase_count = -6;
      pixels_done = '0;
      fine_x_left = '0;
      fine_y = '0;
      tile_col = '0;
      row_base = MAP_BASE;
      held_addr = '0;
      shift_lo = '0;
      shift_hi = '0;
      fetch_lo = '0;
      fetch_hi = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_MAP_SELECT:  map_sel = val[0];
        REG_DATA_SELECT: data_sel = val[0];
        REG_SCROLL_X:    scx = val;
        REG_SCROLL_Y:    scy = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] tile_row_address(logic [7:0] id);
      logic [15:0] a;
      a = TILE_BASE;
      // signed addressing: ids 0..127 live above the 0x8800 block
      if (!data_sel && !id[7]) a = a | TILE_HIGH;
      a = a | {4'b0, id, 4'b0} | {12'b0, fine_y, 1'b0};
      return a;
    endfunction

    function bit line_active();
      return active;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // returns 1 when the beat does real work (start or tick inside a line)
    function bit note_input(opcode_t op, logic [7:0] line, logic [7:0] data);
      logic [7:0]  yoff;
      logic [2:0]  p;
      fetch_beat_t beat;
      beat = '0;
      if (op == OP_START) begin
        yoff = line + scy;
        active = 1'b1;
        phase_count = -6;
        pixels_done = '0;
        row_base = MAP_BASE | {5'b0, map_sel, 10'b0} | {6'b0, yoff[7:3], 5'b0};
        tile_col = scx[7:3];
        fine_x_left = scx[2:0];
        fine_y = yoff[2:0];
        shift_lo = '0;
        shift_hi = '0;
        fetch_lo = '0;
        fetch_hi = '0;
        return 1'b1;
      end
      if (!active) return 1'b0;

      if (phase_count < 0) p = 3'(phase_count + 6);
      else p = 3'(phase_count);
      case (phase_t'(p))
        PH_MAP_ADDR: begin
          shift_lo = fetch_lo;
          shift_hi = fetch_hi;
          held_addr = row_base | {11'b0, tile_col};
          beat.address_valid = 1'b1;
        end
        PH_ID_READ: beat.read_request = 1'b1;
        PH_DATA_ADDR: begin
          held_addr = tile_row_address(data);
          beat.address_valid = 1'b1;
          beat.read_request = 1'b1;
        end
        PH_TAKE_LOW: fetch_lo = data;
        PH_HIGH_ADDR: begin
          held_addr = held_addr + 16'd1;
          beat.address_valid = 1'b1;
          beat.read_request = 1'b1;
        end
        PH_TAKE_HIGH: fetch_hi = data;
        PH_NEXT_COL: tile_col = tile_col + 5'd1;
        default: ;
      endcase

      if (phase_count >= 8) begin
        if (fine_x_left == 0) begin
          beat.pixel_valid = 1'b1;
          beat.pixel_x = pixels_done;
          beat.pixel_color = {shift_hi[7], shift_lo[7]};
          pixels_done = pixels_done + 8'd1;
        end else begin
          fine_x_left = fine_x_left - 3'd1;
        end
      end
      phase_count = phase_count + 1;
      // long lines fold back so the phase stays the same
      if (phase_count >= 16) phase_count = phase_count - 8;
      shift_lo = shift_lo << 1;
      shift_hi = shift_hi << 1;
      if (pixels_done == 8'(line_len)) begin
        beat.line_done = 1'b1;
        active = 1'b0;
      end
      beat.bus_address = held_addr;
      expected_beats.push_back(beat);
      return 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(fetch_beat_t got);
      fetch_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: address %0h", got.bus_address);
        fails++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("bus_address", want.bus_address, got.bus_address);
      compare_field("address_valid", want.address_valid, got.address_valid);
      compare_field("read_request", want.read_request, got.read_request);
      compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_color", want.pixel_color, got.pixel_color);
      compare_field("line_done", want.line_done, got.line_done);
    endfunction
  endclass

endpackage

>>> bench/bg_scanline_tile_fetcher_test.sv
// testbench top: drives start and tick beats through the tile fetcher and checks every result
`timescale 1ns / 1ps

module bg_scanline_tile_fetcher_test;
  import bgstf_pkg::*;
  import fetch_check_pkg::*;

  localparam int unsigned LINE_PX = 160;
  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_line_number = '0;
  logic [7:0]  in_bus_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_bus_address;
  logic        out_address_valid;
  logic        out_read_request;
  logic        out_pixel_valid;
  logic [7:0]  out_pixel_x;
  logic [1:0]  out_pixel_color;
  logic        out_line_done;

  fetch_scoreboard sb;
  int unsigned     items_done = 0;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;
  bit              calm = 1'b0;

  bg_scanline_tile_fetcher #(.LINE_PIXELS(LINE_PX)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_line_number(in_line_number),
    .in_bus_data(in_bus_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bus_address(out_bus_address),
    .out_address_valid(out_address_valid),
    .out_read_request(out_read_request),
    .out_pixel_valid(out_pixel_valid),
    .out_pixel_x(out_pixel_x),
    .out_pixel_color(out_pixel_color),
    .out_line_done(out_line_done)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_bus_address, out_address_valid, out_read_request,
                        out_pixel_valid, out_pixel_x, out_pixel_color, out_line_done});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bg_scanline_tile_fetcher_test failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic ms, input logic ds,
                                input logic [7:0] sx, input logic [7:0] sy);
    write_reg(REG_MAP_SELECT, {7'b0, ms});
    write_reg(REG_DATA_SELECT, {7'b0, ds});
    write_reg(REG_SCROLL_X, sx);
    write_reg(REG_SCROLL_Y, sy);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high between back-to-back beats; it only drops for a gap
  task automatic send_beat(input opcode_t op, input logic [7:0] line, input logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_line_number <= line;
    in_bus_data <= data;
    do @(posedge clk); while (!in_ready);
    if (sb.note_input(op, line, data)) items_done++;
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom_range(0, 153)), 8'($urandom));
  endtask

  // a broken line is cut short by the next start
  task automatic run_line(input bit broken);
    repeat ($urandom_range(0, 2)) send_tick();
    send_beat(OP_START, 8'($urandom_range(0, 153)), 8'($urandom));
    if (broken) begin
      repeat ($urandom_range(1, 80)) send_tick();
    end else begin
      while (sb.line_active()) send_tick();
    end
  endtask

  // finish the line, then let the result register empty before touching registers
  task automatic drain();
    while (sb.line_active()) send_tick();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb = new(LINE_PX);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings(1'b0, 1'b1, 8'd0, 8'd0);
    // ticks before any start do nothing
    send_beat(OP_TICK, 8'd153, 8'hff);
    send_beat(OP_TICK, 8'd0, 8'h00);
    send_beat(OP_START, 8'd0, 8'h00);
    // lead-in: map addr, id read, tile id, low byte, high addr, high byte
    send_beat(OP_TICK, 8'd0, 8'h00);
    send_beat(OP_TICK, 8'd0, 8'hff);
    send_beat(OP_TICK, 8'd0, 8'hff);
    send_beat(OP_TICK, 8'd0, 8'hff);
    send_beat(OP_TICK, 8'd0, 8'h00);
    send_beat(OP_TICK, 8'd0, 8'haa);
    send_beat(OP_TICK, 8'd0, 8'h00);
    send_beat(OP_TICK, 8'd0, 8'h80);
    send_beat(OP_TICK, 8'd0, 8'h80);
    send_beat(OP_TICK, 8'd0, 8'h7f);
    send_beat(OP_TICK, 8'd0, 8'h01);
    send_beat(OP_TICK, 8'd0, 8'hfe);
    // restart while the line is still running
    send_beat(OP_START, 8'd153, 8'h55);
    send_beat(OP_TICK, 8'd0, 8'h00);
    send_beat(OP_TICK, 8'd0, 8'h7f);
    send_beat(OP_TICK, 8'd0, 8'h7f);
    send_beat(OP_TICK, 8'd0, 8'hff);
    drain();

    for (int ph = 0; items_done < ITEM_TARGET; ph++) begin
      calm = (ph % 3 == 2);
      case (ph)
        0: apply_settings(1'b1, 1'b0, 8'd255, 8'd255);
        1: apply_settings(1'b0, 1'b0, 8'd7, 8'd1);
        2: apply_settings(1'b1, 1'b1, 8'd8, 8'd250);
        3: apply_settings(1'b0, 1'b1, 8'd0, 8'd0);
        default: apply_settings(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if ($urandom_range(0, 2) == 0) run_line(1'b1);
      run_line(1'b0);
      drain();
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.fails == 0) begin
      $display("bg_scanline_tile_fetcher_test passed");
    end else begin
      $display("bg_scanline_tile_fetcher_test failed");
    end
    $finish;
  end

endmodule

>>> bg_scanline_tile_fetcher.f
rtl/bgstf_pkg.sv
rtl/bg_scanline_tile_fetcher.sv
bench/fetch_check_pkg.sv
bench/bg_scanline_tile_fetcher_test.sv
